@@ design/dcmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dcmc_pkg
// Shared types and codes for the debounced contact motor command block.
// ----------------------------------------------------------------------------
package dcmc_pkg;

    // Register map (index = paddr[2])
    localparam int unsigned ADDR_W      = 3;
    localparam int unsigned DATA_W      = 32;
    localparam logic        REG_DEBOUNCE = 1'b0;
    localparam logic        REG_MODE     = 1'b1;

    localparam logic [7:0]  DEBOUNCE_RESET = 8'd4;

    // Contact modes
    localparam logic [2:0] MODE_DIRECT = 3'd0;
    localparam logic [2:0] MODE_CYCLE  = 3'd1;
    localparam logic [2:0] MODE_TOGGLE = 3'd2;
    localparam logic [2:0] MODE_HOLD   = 3'd3;
    localparam logic [2:0] MODE_ANYSTOP = 3'd4;

    // Motor states
    localparam logic [1:0] MOT_STOP = 2'd0;
    localparam logic [1:0] MOT_UP   = 2'd1;
    localparam logic [1:0] MOT_DOWN = 2'd2;

    // Key patterns (bit0 up, bit1 down)
    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_UP   = 2'd1;
    localparam logic [1:0] KEY_DOWN = 2'd2;
    localparam logic [1:0] KEY_BOTH = 2'd3;

    typedef struct packed {
        logic       up_pin_level;
        logic       down_pin_level;
        logic [1:0] motor_now;
    } t_in_item;

    typedef struct packed {
        logic       status_write;
        logic [1:0] motor_next;
        logic       retarget_pulse;
    } t_out_item;

    // Architectural state carried from beat to beat
    typedef struct packed {
        logic [7:0] settle_count;
        logic [1:0] stable_keys;
        logic [1:0] cycle_step;
        logic [2:0] contact_mode;
    } t_core_state;

    // Four-step cycle: up, stop, down, stop
    function automatic logic [1:0] cycle_motor(input logic [1:0] step);
        logic [1:0] m;
        case (step)
            2'd0:    m = MOT_UP;
            2'd2:    m = MOT_DOWN;
            default: m = MOT_STOP;
        endcase
        return m;
    endfunction

endpackage

@@ design/dcmc_decide.sv @@
// ----------------------------------------------------------------------------
// dcmc_decide
// One-beat debounce and command decision: next state and result item.
// ----------------------------------------------------------------------------
module dcmc_decide (
    input  dcmc_pkg::t_in_item    i_item,
    input  dcmc_pkg::t_core_state i_state,
    input  logic [7:0]            i_debounce_ticks,
    output dcmc_pkg::t_core_state o_state,
    output dcmc_pkg::t_out_item   o_result
);

    logic [1:0] keys;
    logic [7:0] dec_count;
    logic       settled;
    logic [1:0] cmd;

    assign keys      = {~i_item.down_pin_level, ~i_item.up_pin_level};
    assign dec_count = i_state.settle_count - 8'd1;
    assign settled   = (keys != i_state.stable_keys) && (dec_count == 8'd0);

    always_comb begin
        case (keys)
            dcmc_pkg::KEY_UP:   cmd = dcmc_pkg::MOT_UP;
            dcmc_pkg::KEY_DOWN: cmd = dcmc_pkg::MOT_DOWN;
            default:            cmd = dcmc_pkg::MOT_STOP;
        endcase
    end

    always_comb begin
        o_state                 = i_state;
        o_result.status_write   = 1'b0;
        o_result.motor_next     = i_item.motor_now;
        o_result.retarget_pulse = 1'b0;

        if (keys == i_state.stable_keys) begin
            o_state.settle_count = i_debounce_ticks;
        end else if (!settled) begin
            o_state.settle_count = dec_count;
        end else begin
            o_state.settle_count = i_debounce_ticks;
            o_state.stable_keys  = keys;
            if (keys == dcmc_pkg::KEY_NONE) begin
                // release of a single key stops a hold-to-run motor
                if (i_state.contact_mode == dcmc_pkg::MODE_HOLD &&
                    (i_state.stable_keys inside {dcmc_pkg::KEY_UP, dcmc_pkg::KEY_DOWN}))
                begin
                    o_result.status_write = 1'b1;
                    o_result.motor_next   = dcmc_pkg::MOT_STOP;
                end
            end else begin
                o_result.retarget_pulse = 1'b1;
                case (i_state.contact_mode)
                    dcmc_pkg::MODE_DIRECT, dcmc_pkg::MODE_HOLD: begin
                        o_result.status_write = 1'b1;
                        o_result.motor_next   = cmd;
                    end
                    dcmc_pkg::MODE_CYCLE: begin
                        o_result.status_write = 1'b1;
                        o_result.motor_next   = dcmc_pkg::cycle_motor(i_state.cycle_step);
                        o_state.cycle_step    = i_state.cycle_step + 2'd1;
                    end
                    dcmc_pkg::MODE_TOGGLE: begin
                        o_result.status_write = 1'b1;
                        o_result.motor_next   = (i_item.motor_now == cmd) ?
                                                dcmc_pkg::MOT_STOP : cmd;
                    end
                    dcmc_pkg::MODE_ANYSTOP: begin
                        o_result.status_write = 1'b1;
                        o_result.motor_next   = (i_item.motor_now != dcmc_pkg::MOT_STOP) ?
                                                dcmc_pkg::MOT_STOP : cmd;
                    end
                    default: begin
                        // unknown mode: drop the command, fall back to direct
                        o_state.contact_mode = dcmc_pkg::MODE_DIRECT;
                    end
                endcase
            end
        end
    end

endmodule

@@ design/debounced_contact_motor_command_top.sv @@
// ----------------------------------------------------------------------------
// debounced_contact_motor_command_top
// Debounces two active-low motor contacts and turns key changes into motor
// commands under one of five contact modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data): one beat per sampling
//   tick, carrying the raw up and down pin levels and the present motor state.
//   Output channel (o_out_valid / i_out_ready / o_out_data): exactly one beat
//   per input beat, in order: status_write, motor_next (motor_now passed
//   through when nothing is issued) and retarget_pulse.
//   Latency: a result is presented the cycle after its input beat is taken.
//   Throughput: one beat per cycle unless stalled; the per-tick decision is a
//   short counter-and-mode path between input port and result register.
//   Stall: the result register holds while the receiver stalls; the input side
//   keeps accepting whenever that register is empty or is being drained in the
//   same cycle, so a stalled receiver back-pressures after one beat.
//   Config: APB port, debounce_ticks at 0x0 and contact_mode at 0x4; write
//   only while no beat is in flight. pready is tied high.
//   Reset (synchronous, active low): debounce_ticks = 4, contact_mode =
//   direct, settle counter = 4, stable keys = none, cycle step = 0, and the
//   result register is emptied. No clearing pass is needed.
// ----------------------------------------------------------------------------
module debounced_contact_motor_command_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dcmc_pkg::t_in_item            i_in_data,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dcmc_pkg::t_out_item           o_out_data,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcmc_pkg::ADDR_W-1:0]   paddr,
    input  logic [dcmc_pkg::DATA_W-1:0]   pwdata,
    output logic [dcmc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    dcmc_pkg::t_core_state r_state;
    dcmc_pkg::t_core_state n_state;
    logic [7:0]            r_debounce_ticks;
    logic                  r_out_valid;
    dcmc_pkg::t_out_item   r_out_data;
    dcmc_pkg::t_out_item   n_out_data;

    logic in_beat;
    logic out_beat;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Take a new beat when the result register is free or draining now
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;
    assign out_beat   = r_out_valid && i_out_ready;

    dcmc_decide u_decide (
        .i_item           (i_in_data),
        .i_state          (r_state),
        .i_debounce_ticks (r_debounce_ticks),
        .o_state          (n_state),
        .o_result         (n_out_data)
    );

    // Hold state and config; advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks     <= dcmc_pkg::DEBOUNCE_RESET;
            r_state.settle_count <= dcmc_pkg::DEBOUNCE_RESET;
            r_state.stable_keys  <= dcmc_pkg::KEY_NONE;
            r_state.cycle_step   <= 2'd0;
            r_state.contact_mode <= dcmc_pkg::MODE_DIRECT;
        end else begin
            if (in_beat) begin
                r_state <= n_state;
            end
            // config writes must land only while idle (user's duty, not enforced); a write wins over a beat
            if (cfg_write) begin
                if (paddr[2] == dcmc_pkg::REG_DEBOUNCE) begin
                    r_debounce_ticks <= pwdata[7:0];
                end else begin
                    r_state.contact_mode <= pwdata[2:0];
                end
            end
        end
    end

    // Result register: load on an input beat, drop on an output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Register readback
    always_comb begin
        if (paddr[2] == dcmc_pkg::REG_DEBOUNCE) begin
            prdata = {{(dcmc_pkg::DATA_W-8){1'b0}}, r_debounce_ticks};
        end else begin
            prdata = {{(dcmc_pkg::DATA_W-3){1'b0}}, r_state.contact_mode};
        end
    end

`ifndef SYNTHESIS
    // An issued motor state is always a legal code
    a_issued_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status_write) |-> (o_out_data.motor_next != 2'd3))
        else $error("issued motor state is not a legal code");

    // Every accepted beat yields a pending result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_out_valid)
        else $error("accepted beat produced no result");

    // Stable key pattern moves only on an accepted beat
    a_keys_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_beat |=> $stable(r_state.stable_keys))
        else $error("stable keys changed without an input beat");

    // Cycle step moves only on an accepted beat
    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_beat |=> $stable(r_state.cycle_step))
        else $error("cycle step changed without an input beat");

    // A stalled result is not overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !in_beat)
        else $error("result register overwritten while stalled");
`endif

endmodule
